FILE: src/usmg_pkg.sv
// shared types, constants and tables of the uv sphere mesh generator
package usmg_pkg;

  localparam int FRAC_BITS_DEF = 14;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PARALLELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MERIDIANS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd2;

  localparam logic [7:0]  PARALLELS_RST = 8'd16;
  localparam logic [7:0]  MERIDIANS_RST = 8'd16;
  localparam logic [7:0]  PARALLELS_MIN = 8'd2;
  localparam logic [7:0]  MERIDIANS_MIN = 8'd3;
  localparam logic [15:0] RADIUS_RST    = 16'd256;

  typedef enum logic {
    OP_VERTEX = 1'b0,
    OP_CELL   = 1'b1
  } opcode_e;

  // divider: 8 integer bits of dividend over a 32-bit phase fraction
  localparam int PHASE_W = 32;
  localparam int DIV_NW  = PHASE_W + 8;
  localparam int DIV_DW  = 9;

  // cordic in Q4.30
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int MATH_LAT     = 4;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [PHASE_W-1:0] HALF_TURN    = 32'h8000_0000;

  typedef struct packed {
    logic north;
    logic south;
  } usmg_pole_t;

  typedef struct packed {
    logic        valid;
    opcode_e     op;
    logic        north;
    logic        south;
    logic        two;
    logic [7:0]  ring;
    logic [7:0]  seg;
    logic [16:0] idx;
    logic [14:0] tex_u;
    logic [14:0] tex_v;
  } usmg_side_t;

  // arctangent of 2^-k as a phase (2^32 = full turn)
  function automatic logic [CORDIC_W-1:0] cordic_atan(input logic [4:0] k);
    logic [31:0] a;
    case (k)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return {2'b00, a};
  endfunction

endpackage

FILE: src/usmg_div.sv
// pipelined restoring divider, one quotient bit per stage
module usmg_div import usmg_pkg::*; #(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quot_o
);

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, nq_in[NW-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nq_q[k]  <= {nq_in[NW-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quot_o = nq_q[NW-1];

endmodule

FILE: src/usmg_cordic.sv
// pipelined cordic giving cosine and sine of a 32-bit phase
module usmg_cordic import usmg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [PHASE_W-1:0]        phase_i,
  output logic signed [FRAC_BITS+1:0] cos_o,
  output logic signed [FRAC_BITS+1:0] sin_o
);

  localparam int NW = FRAC_BITS + 2;
  localparam int SH = CORDIC_FRAC - FRAC_BITS;
  localparam logic signed [CORDIC_W-1:0] HALF_U = CORDIC_W'(64'd1 << (SH - 1));
  localparam logic signed [CORDIC_W-1:0] ONE_U  = CORDIC_W'(64'd1 << FRAC_BITS);

  logic signed [CORDIC_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] z_q [CORDIC_STEPS+1];
  logic                       f_q [CORDIC_STEPS+1];

  logic [PHASE_W-1:0] ph_sum;
  logic [PHASE_W-1:0] ph;
  logic               flip;

  function automatic logic signed [NW-1:0] to_unit(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    r = (v + HALF_U) >>> SH;
    if (r > ONE_U) r = ONE_U;
    else if (r < -ONE_U) r = -ONE_U;
    return NW'(r);
  endfunction

  // fold into the right half plane
  assign ph_sum = phase_i + QUARTER_TURN;
  assign flip   = ph_sum[PHASE_W-1];
  assign ph     = flip ? phase_i + HALF_TURN : phase_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CORDIC_GAIN;
      y_q[0] <= '0;
      z_q[0] <= {{(CORDIC_W-PHASE_W){ph[PHASE_W-1]}}, ph};
      f_q[0] <= flip;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] at;

    assign dx = y_q[k] >>> k;
    assign dy = x_q[k] >>> k;
    assign at = signed'(cordic_atan(5'(k)));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[k][CORDIC_W-1]) begin
          x_q[k+1] <= x_q[k] - dx;
          y_q[k+1] <= y_q[k] + dy;
          z_q[k+1] <= z_q[k] - at;
        end else begin
          x_q[k+1] <= x_q[k] + dx;
          y_q[k+1] <= y_q[k] - dy;
          z_q[k+1] <= z_q[k] + at;
        end
        f_q[k+1] <= f_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (f_q[CORDIC_STEPS]) begin
        cos_o <= to_unit(-x_q[CORDIC_STEPS]);
        sin_o <= to_unit(-y_q[CORDIC_STEPS]);
      end else begin
        cos_o <= to_unit(x_q[CORDIC_STEPS]);
        sin_o <= to_unit(y_q[CORDIC_STEPS]);
      end
    end
  end

endmodule

FILE: src/usmg_math.sv
// normal and position arithmetic after the sine and cosine units
module usmg_math import usmg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [FRAC_BITS+1:0] ct_i,
  input  logic signed [FRAC_BITS+1:0] st_i,
  input  logic signed [FRAC_BITS+1:0] cp_i,
  input  logic signed [FRAC_BITS+1:0] sp_i,
  input  usmg_pole_t                  pole_i,
  input  logic [15:0]                 radius_i,
  output logic signed [23:0]          pos_x_o,
  output logic signed [23:0]          pos_y_o,
  output logic signed [23:0]          pos_z_o,
  output logic signed [15:0]          norm_x_o,
  output logic signed [15:0]          norm_y_o,
  output logic signed [15:0]          norm_z_o
);

  localparam int NW = FRAC_BITS + 2;
  localparam int PW = 2 * NW;
  localparam int QW = NW + 17;
  localparam logic signed [PW-1:0] HALF_N = PW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [NW-1:0] ONE_N  = NW'(64'd1 << FRAC_BITS);
  localparam logic signed [QW-1:0] HALF_P = QW'(128);

  logic signed [PW-1:0] px_q, py_q;
  logic signed [NW-1:0] ct_q;
  usmg_pole_t           pole_q;

  logic signed [PW-1:0] rx, ry;
  logic signed [NW-1:0] nx_q, ny_q, nz_q;

  logic signed [QW-1:0] rad_s;
  logic signed [QW-1:0] qx_q, qy_q, qz_q;
  logic signed [NW-1:0] nx2_q, ny2_q, nz2_q;

  logic signed [QW-1:0] sx, sy, sz;

  // stage 1: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q   <= PW'(st_i) * PW'(cp_i);
      py_q   <= PW'(st_i) * PW'(sp_i);
      ct_q   <= ct_i;
      pole_q <= pole_i;
    end
  end

  // stage 2: rounding and pole override
  assign rx = (px_q + HALF_N) >>> FRAC_BITS;
  assign ry = (py_q + HALF_N) >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (pole_q.north || pole_q.south) begin
        nx_q <= '0;
        ny_q <= '0;
        nz_q <= pole_q.north ? ONE_N : -ONE_N;
      end else begin
        nx_q <= NW'(rx);
        ny_q <= NW'(ry);
        nz_q <= ct_q;
      end
    end
  end

  // stage 3: scale by radius
  assign rad_s = QW'(signed'({1'b0, radius_i}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qx_q  <= QW'(nx_q) * rad_s;
      qy_q  <= QW'(ny_q) * rad_s;
      qz_q  <= QW'(nz_q) * rad_s;
      nx2_q <= nx_q;
      ny2_q <= ny_q;
      nz2_q <= nz_q;
    end
  end

  // stage 4: round to Q(24-F).F
  assign sx = (qx_q + HALF_P) >>> 8;
  assign sy = (qy_q + HALF_P) >>> 8;
  assign sz = (qz_q + HALF_P) >>> 8;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_x_o  <= 24'(sx);
      pos_y_o  <= 24'(sy);
      pos_z_o  <= 24'(sz);
      norm_x_o <= 16'(nx2_q);
      norm_y_o <= 16'(ny2_q);
      norm_z_o <= 16'(nz2_q);
    end
  end

endmodule

FILE: src/uv_sphere_mesh_generator.sv
// top level of the uv sphere mesh generator
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_stall_o   opcode_i, ring_i, segment_i
//  out      source     out_valid_o / out_stall_i pos, norm, tex, index_a..c, last_o
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  one request enters per cycle while in_stall_o is low; it passes the request register,
//  the bit-per-stage dividers, the cordic stages, the maths stages and the output register
//  a middle face cell gives two triangles and holds the output register until both are taken
//  reset clears the valid bits and loads the register reset values
//  a stall at the output freezes the whole pipeline; nothing is dropped or repeated
module uv_sphere_mesh_generator import usmg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  opcode_i,
  input  logic [7:0]            ring_i,
  input  logic [7:0]            segment_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [23:0]    pos_x_o,
  output logic signed [23:0]    pos_y_o,
  output logic signed [23:0]    pos_z_o,
  output logic signed [15:0]    norm_x_o,
  output logic signed [15:0]    norm_y_o,
  output logic signed [15:0]    norm_z_o,
  output logic [14:0]           tex_u_o,
  output logic [14:0]           tex_v_o,
  output logic [15:0]           index_a_o,
  output logic [15:0]           index_b_o,
  output logic [15:0]           index_c_o,
  output logic                  last_o,
  // configuration channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NW       = FRAC_BITS + 2;
  localparam int CL       = DIV_NW + CORDIC_LAT;
  localparam int PIPE_END = CL + MATH_LAT;

  // configuration registers; parallels and meridians are stored already clamped to their minimum
  logic [7:0]  par_q, mer_q;
  logic [15:0] rad_q;
  logic [7:0]  cfg_v8;

  assign cfg_ready_o = 1'b1;
  assign cfg_v8      = cfg_data_i[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q <= PARALLELS_RST;
      mer_q <= MERIDIANS_RST;
      rad_q <= RADIUS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PARALLELS: par_q <= (cfg_v8 < PARALLELS_MIN) ? PARALLELS_MIN : cfg_v8;
        CFG_MERIDIANS: mer_q <= (cfg_v8 < MERIDIANS_MIN) ? MERIDIANS_MIN : cfg_v8;
        CFG_RADIUS:    rad_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // global advance: output register empty or handing over its final result
  logic en;
  logic out_v_q, phase_q, two_q, north_q;
  logic out_fin;

  assign out_fin    = !two_q || phase_q;
  assign en         = !out_v_q || (!out_stall_i && out_fin);
  assign in_stall_o = !en;

  // side pipeline: item control and index data travelling alongside the maths
  usmg_side_t sd_q [PIPE_END+1];
  usmg_side_t sd_d [PIPE_END+1];

  logic [7:0] par_m1, mer_m1;
  logic [7:0] iv, jv, ic, jc;
  logic [8:0] wid;

  assign par_m1 = par_q - 8'd1;
  assign mer_m1 = mer_q - 8'd1;
  assign wid    = {1'b0, mer_q} + 9'd1;
  assign iv     = (ring_i > par_q) ? par_q : ring_i;
  assign jv     = (segment_i > mer_q) ? mer_q : segment_i;
  assign ic     = (ring_i > par_m1) ? par_m1 : ring_i;
  assign jc     = (segment_i > mer_m1) ? mer_m1 : segment_i;

  // request stage: clamping and pole detection
  always_comb begin
    sd_d[0]       = '0;
    sd_d[0].valid = in_valid_i;
    sd_d[0].op    = opcode_e'(opcode_i);
    if (opcode_e'(opcode_i) == OP_VERTEX) begin
      sd_d[0].ring  = iv;
      sd_d[0].seg   = jv;
      sd_d[0].north = (iv == 8'd0);
      sd_d[0].south = (iv == par_q);
    end else begin
      sd_d[0].ring  = ic;
      sd_d[0].seg   = jc;
      sd_d[0].north = (ic == 8'd0);
      sd_d[0].south = (ic == par_m1);
      sd_d[0].two   = (ic != 8'd0) && (ic != par_m1);
    end
  end

  // dividers for the two phases and the texture coordinates
  logic [DIV_NW-1:0] num_th, num_ph, num_u, num_v;
  logic [DIV_NW-1:0] q_th, q_ph, q_u, q_v;
  logic [7:0]        p_minus_i;

  assign p_minus_i = par_q - sd_q[0].ring;
  assign num_th    = {sd_q[0].ring, {PHASE_W{1'b0}}};
  assign num_ph    = {sd_q[0].seg, {PHASE_W{1'b0}}};
  // a pole centres u in its column: (2j+1)/2m, the middle rows use 2j/2m
  assign num_u     = (DIV_NW'({sd_q[0].seg, sd_q[0].north | sd_q[0].south}) << FRAC_BITS)
                     + DIV_NW'(mer_q);
  assign num_v     = (DIV_NW'({p_minus_i, 1'b0}) << FRAC_BITS) + DIV_NW'(par_q);

  usmg_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_th (
    .clk_i (clk_i), .en_i (en), .num_i (num_th), .den_i ({1'b0, par_q}), .quot_o (q_th)
  );
  usmg_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_ph (
    .clk_i (clk_i), .en_i (en), .num_i (num_ph), .den_i ({1'b0, mer_q}), .quot_o (q_ph)
  );
  usmg_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_u (
    .clk_i (clk_i), .en_i (en), .num_i (num_u), .den_i ({mer_q, 1'b0}), .quot_o (q_u)
  );
  usmg_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_v (
    .clk_i (clk_i), .en_i (en), .num_i (num_v), .den_i ({par_q, 1'b0}), .quot_o (q_v)
  );

  // side stages: vertex index base, then texture coordinates joining
  for (genvar k = 1; k <= PIPE_END; k++) begin : g_side
    if (k == 1) begin : g_mul
      always_comb begin
        sd_d[k]     = sd_q[k-1];
        sd_d[k].idx = 17'(sd_q[k-1].ring) * 17'(wid);
      end
    end else if (k == 2) begin : g_add
      always_comb begin
        sd_d[k]     = sd_q[k-1];
        sd_d[k].idx = sd_q[k-1].idx + 17'(sd_q[k-1].seg);
      end
    end else if (k == DIV_NW + 1) begin : g_tex
      always_comb begin
        sd_d[k]       = sd_q[k-1];
        sd_d[k].tex_u = q_u[14:0];
        sd_d[k].tex_v = q_v[14:0];
      end
    end else begin : g_pass
      assign sd_d[k] = sd_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= PIPE_END; k++) sd_q[k] <= '0;
    end else if (en) begin
      for (int k = 0; k <= PIPE_END; k++) sd_q[k] <= sd_d[k];
    end
  end

  // sine and cosine of latitude and longitude
  logic signed [NW-1:0] ct, st, cp, sp;

  usmg_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic_th (
    .clk_i (clk_i), .en_i (en), .phase_i ({1'b0, q_th[PHASE_W-1:1]}),
    .cos_o (ct), .sin_o (st)
  );
  usmg_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic_ph (
    .clk_i (clk_i), .en_i (en), .phase_i (q_ph[PHASE_W-1:0]),
    .cos_o (cp), .sin_o (sp)
  );

  // normal and position
  usmg_pole_t           pole;
  logic signed [23:0]   m_px, m_py, m_pz;
  logic signed [15:0]   m_nx, m_ny, m_nz;

  assign pole.north = sd_q[CL].north;
  assign pole.south = sd_q[CL].south;

  usmg_math #(.FRAC_BITS(FRAC_BITS)) u_math (
    .clk_i    (clk_i),
    .en_i     (en),
    .ct_i     (ct),
    .st_i     (st),
    .cp_i     (cp),
    .sp_i     (sp),
    .pole_i   (pole),
    .radius_i (rad_q),
    .pos_x_o  (m_px),
    .pos_y_o  (m_py),
    .pos_z_o  (m_pz),
    .norm_x_o (m_nx),
    .norm_y_o (m_ny),
    .norm_z_o (m_nz)
  );

  // output register; a middle cell sends its second triangle from here
  usmg_side_t         fin;
  logic [15:0]        base, nb;
  logic [15:0]        base_q, nb_q, base1_q, nb1_q;
  logic signed [23:0] px_q, py_q, pz_q;
  logic signed [15:0] nx_q, ny_q, nz_q;
  logic [14:0]        tu_q, tv_q;

  assign fin  = sd_q[PIPE_END];
  assign base = fin.idx[15:0];
  assign nb   = base + 16'(wid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      phase_q <= 1'b0;
      two_q   <= 1'b0;
    end else if (en) begin
      out_v_q <= fin.valid;
      phase_q <= 1'b0;
      two_q   <= (fin.op == OP_CELL) && fin.two;
    end else if (out_v_q && !out_stall_i) begin
      phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (fin.op == OP_VERTEX) begin
        px_q    <= m_px;
        py_q    <= m_py;
        pz_q    <= m_pz;
        nx_q    <= m_nx;
        ny_q    <= m_ny;
        nz_q    <= m_nz;
        tu_q    <= fin.tex_u;
        tv_q    <= fin.tex_v;
        base_q  <= '0;
        nb_q    <= '0;
        base1_q <= '0;
        nb1_q   <= '0;
        north_q <= 1'b0;
      end else begin
        px_q    <= '0;
        py_q    <= '0;
        pz_q    <= '0;
        nx_q    <= '0;
        ny_q    <= '0;
        nz_q    <= '0;
        tu_q    <= '0;
        tv_q    <= '0;
        base_q  <= base;
        nb_q    <= nb;
        base1_q <= base + 16'd1;
        nb1_q   <= nb + 16'd1;
        north_q <= fin.north;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign pos_x_o     = px_q;
  assign pos_y_o     = py_q;
  assign pos_z_o     = pz_q;
  assign norm_x_o    = nx_q;
  assign norm_y_o    = ny_q;
  assign norm_z_o    = nz_q;
  assign tex_u_o     = tu_q;
  assign tex_v_o     = tv_q;
  // north cap closes on the next ring; other first triangles close on this ring
  assign index_a_o   = phase_q ? nb_q : base_q;
  assign index_b_o   = phase_q ? nb1_q : nb_q;
  assign index_c_o   = (phase_q || !north_q) ? base1_q : nb1_q;
  assign last_o      = out_fin;

endmodule
